/* design/fjr_pkg.sv */
// fjr_pkg: shared types, mode codes, register indexes and reset values
// for the feeder jam recovery block. No dependencies.
`timescale 1ns / 1ps
package fjr_pkg;

	localparam int MODE_W   = 4;
	localparam int SPEED_W  = 16;
	localparam int BAND_W   = 10;
	localparam int JAM_W    = 10;
	localparam int REV_W    = 16;
	localparam int UNIT_W   = 10;
	localparam int MULT_W   = 5;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	typedef logic [MODE_W-1:0]         mode_t;
	typedef logic signed [SPEED_W-1:0] speed_t;
	typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0]     cfg_data_t;

	// mode codes; everything above MODE_RUN_LAST is an idle code
	localparam mode_t MODE_START     = 4'd0;
	localparam mode_t MODE_STOP      = 4'd1;
	localparam mode_t MODE_REVERSE   = 4'd2;
	localparam mode_t MODE_RUN_FIRST = 4'd3;
	localparam mode_t MODE_RUN_LAST  = 4'd9;

	// configuration register indexes
	localparam cfg_idx_t CFG_STALL_BAND    = 8'd0;
	localparam cfg_idx_t CFG_JAM_TICKS     = 8'd1;
	localparam cfg_idx_t CFG_REVERSE_TICKS = 8'd2;
	localparam cfg_idx_t CFG_UNIT_SPEED    = 8'd3;

	localparam logic [BAND_W-1:0] STALL_BAND_RST    = 10'd20;
	localparam logic [JAM_W-1:0]  JAM_TICKS_RST     = 10'd60;
	localparam logic [REV_W-1:0]  REVERSE_TICKS_RST = 16'd300;
	localparam logic [UNIT_W-1:0] UNIT_SPEED_RST    = 10'd100;

	// setpoint multiplier of each run rate
	function automatic logic [MULT_W-1:0] run_mult(input logic [2:0] idx);
		logic [MULT_W-1:0] m;
		unique case (idx)
			3'd0:    m = 5'd3;
			3'd1:    m = 5'd5;
			3'd2:    m = 5'd6;
			3'd3:    m = 5'd8;
			3'd4:    m = 5'd10;
			3'd5:    m = 5'd15;
			3'd6:    m = 5'd20;
			default: m = 5'd0;
		endcase
		return m;
	endfunction

endpackage

/* design/fjr_if.sv */
// fjr_if: valid/ready channel interfaces for ticks, results and register writes.
// Depends on fjr_pkg.
`timescale 1ns / 1ps
interface fjr_tick_if;
	logic               valid;
	logic               ready;
	fjr_pkg::mode_t     mode_request;
	fjr_pkg::speed_t    measured_speed;
	logic               ball_present;

	modport source (output valid, mode_request, measured_speed, ball_present, input ready);
	modport sink   (input valid, mode_request, measured_speed, ball_present, output ready);
endinterface

interface fjr_result_if;
	logic               valid;
	logic               ready;
	fjr_pkg::mode_t     current_mode;
	fjr_pkg::speed_t    speed_setpoint;

	modport source (output valid, current_mode, speed_setpoint, input ready);
	modport sink   (input valid, current_mode, speed_setpoint, output ready);
endinterface

interface fjr_cfg_if;
	logic                valid;
	logic                ready;
	fjr_pkg::cfg_idx_t   index;
	fjr_pkg::cfg_data_t  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* design/feeder_jam_recovery_fsm.sv */
// feeder_jam_recovery_fsm: feeder mode control with stall-based jam recovery.
// Depends on fjr_pkg and the channel interfaces in fjr_if.sv.
//
//   channel   dir   payload                                   
//   tick      in    mode_request, measured_speed, ball_present
//   result    out   current_mode, speed_setpoint              
//   cfg       in    index, data (always ready)                
//
// One tick per cycle sustained while results are taken; a tick passes the tick register,
// then the result register. The tick register feeds combinational mode/counter logic that
// updates state and the result register in the same edge, closing the state loop.
// The tick stage holds only while the result register is full and not taken.
// arst_n clears state, counters and valid flags; config registers return to reset values.
`timescale 1ns / 1ps
module feeder_jam_recovery_fsm (
	input  logic            clk,
	input  logic            arst_n,
	fjr_tick_if.sink        tick,
	fjr_result_if.source    result,
	fjr_cfg_if.sink         cfg
);
	import fjr_pkg::*;

	// configuration registers
	logic [BAND_W-1:0] band_q;
	logic [JAM_W-1:0]  jam_ticks_q;
	logic [REV_W-1:0]  rev_ticks_q;
	logic [UNIT_W-1:0] unit_q;

	// tick stage
	logic   valid_s1;
	mode_t  req_s1;
	speed_t speed_s1;
	logic   ball_s1;

	// block state
	mode_t             mode_q, mode_d;
	mode_t             ret_mode_q, ret_mode_d;
	speed_t            prev_sp_q, sp_d;
	logic [JAM_W-1:0]  stall_cnt_q, stall_cnt_d;
	logic [REV_W-1:0]  rev_cnt_q, rev_cnt_d;

	// result register
	logic   res_valid_q;
	mode_t  res_mode_q;
	speed_t res_sp_q;

	logic              adv;
	mode_t             mode_in;
	logic              is_run, check_jam, stalled, jam_fire, rev_done;
	logic [SPEED_W:0]  speed_ext, mag;
	logic [JAM_W-1:0]  stall_inc;
	logic [REV_W-1:0]  rev_inc;
	mode_t             run_off;
	logic [SPEED_W-1:0] unit_ext;
	logic [MULT_W+UNIT_W-1:0] run_prod;

	assign adv         = valid_s1 && (!res_valid_q || result.ready);
	assign tick.ready  = !valid_s1 || adv;
	assign cfg.ready   = 1'b1;

	assign result.valid          = res_valid_q;
	assign result.current_mode   = res_mode_q;
	assign result.speed_setpoint = res_sp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q      <= STALL_BAND_RST;
			jam_ticks_q <= JAM_TICKS_RST;
			rev_ticks_q <= REVERSE_TICKS_RST;
			unit_q      <= UNIT_SPEED_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_STALL_BAND:    band_q      <= cfg.data[BAND_W-1:0];
				CFG_JAM_TICKS:     jam_ticks_q <= cfg.data[JAM_W-1:0];
				CFG_REVERSE_TICKS: rev_ticks_q <= cfg.data[REV_W-1:0];
				CFG_UNIT_SPEED:    unit_q      <= cfg.data[UNIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			req_s1   <= tick.mode_request;
			speed_s1 <= tick.measured_speed;
			ball_s1  <= tick.ball_present;
		end
	end

	// next-mode logic
	always_comb begin
		mode_in   = (mode_q != MODE_START && mode_q != MODE_REVERSE) ? req_s1 : mode_q;
		is_run    = (mode_in >= MODE_RUN_FIRST) && (mode_in <= MODE_RUN_LAST);
		check_jam = is_run || (mode_in == MODE_START);

		speed_ext = {speed_s1[SPEED_W-1], speed_s1};
		mag       = speed_s1[SPEED_W-1] ? ((SPEED_W+1)'(0) - speed_ext) : speed_ext;
		stalled   = (prev_sp_q != '0) && (mag <= {{(SPEED_W+1-BAND_W){1'b0}}, band_q});
		stall_inc = stall_cnt_q + JAM_W'(1);
		jam_fire  = stalled && (stall_inc >= jam_ticks_q);

		rev_inc   = rev_cnt_q + REV_W'(1);
		rev_done  = rev_inc >= rev_ticks_q;

		mode_d      = mode_in;
		ret_mode_d  = ret_mode_q;
		stall_cnt_d = stall_cnt_q;
		rev_cnt_d   = rev_cnt_q;

		if (check_jam) begin
			stall_cnt_d = (stalled && !jam_fire) ? stall_inc : '0;
		end

		priority if (is_run || mode_in == MODE_START) begin
			if (jam_fire) begin
				ret_mode_d = mode_in;
				mode_d     = MODE_REVERSE;
			end else if (mode_in == MODE_START && ball_s1) begin
				mode_d = MODE_STOP;
			end
		end else if (mode_in == MODE_REVERSE) begin
			if (rev_done) begin
				mode_d    = ret_mode_q;
				rev_cnt_d = '0;
			end else begin
				rev_cnt_d = rev_inc;
			end
		end else begin
			mode_d = mode_in;
		end

		// setpoint from the new mode
		unit_ext = {{(SPEED_W-UNIT_W){1'b0}}, unit_q};
		run_off  = mode_d - MODE_RUN_FIRST;
		run_prod = run_mult(run_off[2:0]) * unit_q;

		priority if (mode_d == MODE_START) begin
			sp_d = speed_t'(unit_ext << 1);
		end else if (mode_d == MODE_STOP) begin
			sp_d = '0;
		end else if (mode_d == MODE_REVERSE) begin
			sp_d = speed_t'(SPEED_W'(0) - ((unit_ext << 3) + (unit_ext << 1)));
		end else if (mode_d >= MODE_RUN_FIRST && mode_d <= MODE_RUN_LAST) begin
			sp_d = speed_t'({{(SPEED_W-MULT_W-UNIT_W){1'b0}}, run_prod});
		end else begin
			sp_d = prev_sp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_START;
			ret_mode_q  <= MODE_START;
			prev_sp_q   <= '0;
			stall_cnt_q <= '0;
			rev_cnt_q   <= '0;
		end else if (adv) begin
			mode_q      <= mode_d;
			ret_mode_q  <= ret_mode_d;
			prev_sp_q   <= sp_d;
			stall_cnt_q <= stall_cnt_d;
			rev_cnt_q   <= rev_cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_mode_q <= mode_d;
			res_sp_q   <= sp_d;
		end
	end

endmodule

/* design/fjr_checker.sv */
// fjr_checker: port-level checks of the feeder jam recovery block, bound to the top.
// Depends on fjr_pkg and feeder_jam_recovery_fsm.
`timescale 1ns / 1ps
module fjr_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            res_valid,
	input logic            res_ready,
	input fjr_pkg::mode_t  res_mode,
	input fjr_pkg::speed_t res_sp
);
	import fjr_pkg::*;

	// a stalled result holds its value
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_mode) && $stable(res_sp))
		else $error("result changed while stalled");

	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_mode == MODE_STOP |-> res_sp == '0)
		else $error("stop mode with nonzero setpoint");

	a_rev_neg: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_mode == MODE_REVERSE |-> res_sp <= 0)
		else $error("reverse mode with forward setpoint");

	a_fwd_pos: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_mode == MODE_START
			|| (res_mode >= MODE_RUN_FIRST && res_mode <= MODE_RUN_LAST)) |-> res_sp >= 0)
		else $error("forward mode with reverse setpoint");

endmodule

bind feeder_jam_recovery_fsm fjr_checker u_fjr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_mode  (result.current_mode),
	.res_sp    (result.speed_setpoint)
);
